[sv/cau_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, codes and types for the complex arithmetic unit.
package cau_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_SAT      = 2'd1;
  localparam status_t ST_DIV_ZERO = 2'd2;

endpackage

[sv/cau_in_if.sv]
`timescale 1ns / 1ps
// Operand channel: operation code and two complex operands.
interface cau_in_if import cau_pkg::*; #(
  parameter int W = WORD_BITS
) ();
  logic                valid;
  logic                ready;
  op_t                 req_type;
  logic signed [W-1:0] a_re;
  logic signed [W-1:0] a_im;
  logic signed [W-1:0] b_re;
  logic signed [W-1:0] b_im;

  modport source (output valid, req_type, a_re, a_im, b_re, b_im, input ready);
  modport sink   (input valid, req_type, a_re, a_im, b_re, b_im, output ready);
endinterface

[sv/cau_out_if.sv]
`timescale 1ns / 1ps
// Result channel: complex result and status code.
interface cau_out_if import cau_pkg::*; #(
  parameter int W = WORD_BITS
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] res_re;
  logic signed [W-1:0] res_im;
  status_t             status;

  modport source (output valid, res_re, res_im, status, input ready);
  modport sink   (input valid, res_re, res_im, status, output ready);
endinterface

[sv/cau_front.sv]
`timescale 1ns / 1ps
// Front pipeline: operand register, products, sums, magnitudes and divisor.
module cau_front import cau_pkg::*; #(
  parameter int W = WORD_BITS,
  parameter int F = FRAC_BITS,
  localparam int SW = 2*W + 1,
  localparam int NW = SW + F,
  localparam int DW = 2*W
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  op_t                  in_op,
  input  logic signed [W-1:0]  in_a_re,
  input  logic signed [W-1:0]  in_a_im,
  input  logic signed [W-1:0]  in_b_re,
  input  logic signed [W-1:0]  in_b_im,
  output logic                 out_valid,
  output op_t                  out_op,
  output logic                 out_dz,
  output logic                 out_neg_re,
  output logic                 out_neg_im,
  output logic signed [SW-1:0] out_alt_re,
  output logic signed [SW-1:0] out_alt_im,
  output logic [NW-1:0]        out_num_re,
  output logic [NW-1:0]        out_num_im,
  output logic [DW-1:0]        out_den
);

  // stage 1: operand register
  logic                v1_r;
  op_t                 op1_r;
  logic signed [W-1:0] ar1_r, ai1_r, br1_r, bi1_r;

  // stage 2: products, add/sub
  logic                  v2_r;
  op_t                   op2_r;
  logic signed [2*W-1:0] prr2_r, pii2_r, pri2_r, pir2_r, pbr2_r, pbi2_r;
  logic signed [W:0]     asr2_r, asi2_r;
  logic signed [W:0]     asr2_nxt, asi2_nxt;

  // stage 3: sums of products
  logic                  v3_r;
  op_t                   op3_r;
  logic signed [SW-1:0]  mre3_r, mim3_r, nre3_r, nim3_r;
  logic signed [W:0]     asr3_r, asi3_r;
  logic [DW-1:0]         den3_r;

  // stage 4 next values
  logic [SW-1:0]        mag_re, mag_im;
  logic signed [SW-1:0] alt_re_nxt, alt_im_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      out_valid <= v3_r;
    end
  end

  always_comb begin
    if (op1_r == OP_SUB) begin
      asr2_nxt = {ar1_r[W-1], ar1_r} - {br1_r[W-1], br1_r};
      asi2_nxt = {ai1_r[W-1], ai1_r} - {bi1_r[W-1], bi1_r};
    end else begin
      asr2_nxt = {ar1_r[W-1], ar1_r} + {br1_r[W-1], br1_r};
      asi2_nxt = {ai1_r[W-1], ai1_r} + {bi1_r[W-1], bi1_r};
    end
  end

  // magnitudes and the alternate (non-divide) result
  always_comb begin
    mag_re = nre3_r[SW-1] ? (~nre3_r + 1'b1) : nre3_r;
    mag_im = nim3_r[SW-1] ? (~nim3_r + 1'b1) : nim3_r;
    if (op3_r == OP_MUL) begin
      alt_re_nxt = mre3_r >>> F;
      alt_im_nxt = mim3_r >>> F;
    end else begin
      alt_re_nxt = {{(SW-W-1){asr3_r[W]}}, asr3_r};
      alt_im_nxt = {{(SW-W-1){asi3_r[W]}}, asi3_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r  <= in_op;
      ar1_r  <= in_a_re;
      ai1_r  <= in_a_im;
      br1_r  <= in_b_re;
      bi1_r  <= in_b_im;

      op2_r  <= op1_r;
      prr2_r <= ar1_r * br1_r;
      pii2_r <= ai1_r * bi1_r;
      pri2_r <= ar1_r * bi1_r;
      pir2_r <= ai1_r * br1_r;
      pbr2_r <= br1_r * br1_r;
      pbi2_r <= bi1_r * bi1_r;
      asr2_r <= asr2_nxt;
      asi2_r <= asi2_nxt;

      op3_r  <= op2_r;
      mre3_r <= {prr2_r[2*W-1], prr2_r} - {pii2_r[2*W-1], pii2_r};
      mim3_r <= {pri2_r[2*W-1], pri2_r} + {pir2_r[2*W-1], pir2_r};
      nre3_r <= {prr2_r[2*W-1], prr2_r} + {pii2_r[2*W-1], pii2_r};
      nim3_r <= {pir2_r[2*W-1], pir2_r} - {pri2_r[2*W-1], pri2_r};
      den3_r <= DW'($unsigned(pbr2_r)) + DW'($unsigned(pbi2_r));
      asr3_r <= asr2_r;
      asi3_r <= asi2_r;

      out_op     <= op3_r;
      out_dz     <= (den3_r == '0);
      out_neg_re <= nre3_r[SW-1];
      out_neg_im <= nim3_r[SW-1];
      out_alt_re <= alt_re_nxt;
      out_alt_im <= alt_im_nxt;
      out_num_re <= NW'(mag_re) << F;
      out_num_im <= NW'(mag_im) << F;
      out_den    <= den3_r;
    end
  end

endmodule

[sv/cau_div_step.sv]
`timescale 1ns / 1ps
// One restoring division step for both lanes, one quotient bit per stage.
module cau_div_step import cau_pkg::*; #(
  parameter int W   = WORD_BITS,
  parameter int F   = FRAC_BITS,
  parameter int SBW = 8,
  localparam int NW = 2*W + 1 + F,
  localparam int DW = 2*W
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  logic [DW-1:0]  in_rem_re,
  input  logic [DW-1:0]  in_rem_im,
  input  logic [NW-1:0]  in_num_re,
  input  logic [NW-1:0]  in_num_im,
  input  logic [NW-1:0]  in_quo_re,
  input  logic [NW-1:0]  in_quo_im,
  input  logic [DW-1:0]  in_den,
  input  logic [SBW-1:0] in_side,
  output logic           out_valid,
  output logic [DW-1:0]  out_rem_re,
  output logic [DW-1:0]  out_rem_im,
  output logic [NW-1:0]  out_num_re,
  output logic [NW-1:0]  out_num_im,
  output logic [NW-1:0]  out_quo_re,
  output logic [NW-1:0]  out_quo_im,
  output logic [DW-1:0]  out_den,
  output logic [SBW-1:0] out_side
);

  logic [DW:0] sh_re, sh_im, dif_re, dif_im;
  logic        ge_re, ge_im;

  // shift in next numerator bit, trial subtract
  always_comb begin
    sh_re  = {in_rem_re, in_num_re[NW-1]};
    sh_im  = {in_rem_im, in_num_im[NW-1]};
    dif_re = sh_re - {1'b0, in_den};
    dif_im = sh_im - {1'b0, in_den};
    ge_re  = !dif_re[DW];
    ge_im  = !dif_im[DW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem_re <= ge_re ? dif_re[DW-1:0] : sh_re[DW-1:0];
      out_rem_im <= ge_im ? dif_im[DW-1:0] : sh_im[DW-1:0];
      out_num_re <= in_num_re << 1;
      out_num_im <= in_num_im << 1;
      out_quo_re <= {in_quo_re[NW-2:0], ge_re};
      out_quo_im <= {in_quo_im[NW-2:0], ge_im};
      out_den    <= in_den;
      out_side   <= in_side;
    end
  end

endmodule

[sv/cau_sat.sv]
`timescale 1ns / 1ps
// Output stage: sign of quotient, result select, saturation and status.
module cau_sat import cau_pkg::*; #(
  parameter int W = WORD_BITS,
  parameter int F = FRAC_BITS,
  localparam int SW = 2*W + 1,
  localparam int NW = SW + F
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  op_t                 in_op,
  input  logic                in_dz,
  input  logic                in_neg_re,
  input  logic                in_neg_im,
  input  logic signed [SW-1:0] in_alt_re,
  input  logic signed [SW-1:0] in_alt_im,
  input  logic [NW-1:0]       in_quo_re,
  input  logic [NW-1:0]       in_quo_im,
  output logic                out_valid_r,
  output logic signed [W-1:0] out_res_re_r,
  output logic signed [W-1:0] out_res_im_r,
  output status_t             out_status_r
);

  localparam logic signed [NW:0] VMAX = {{(NW-W+2){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [NW:0] VMIN = {{(NW-W+2){1'b1}}, {(W-1){1'b0}}};

  logic signed [NW:0]  v_re, v_im;
  logic signed [W-1:0] s_re, s_im;
  logic                hi_re, lo_re, hi_im, lo_im;

  always_comb begin
    if (in_op == OP_DIV) begin
      v_re = in_neg_re ? -$signed({1'b0, in_quo_re}) : $signed({1'b0, in_quo_re});
      v_im = in_neg_im ? -$signed({1'b0, in_quo_im}) : $signed({1'b0, in_quo_im});
    end else begin
      v_re = {{(NW+1-SW){in_alt_re[SW-1]}}, in_alt_re};
      v_im = {{(NW+1-SW){in_alt_im[SW-1]}}, in_alt_im};
    end
    hi_re = v_re > VMAX;
    lo_re = v_re < VMIN;
    hi_im = v_im > VMAX;
    lo_im = v_im < VMIN;
    s_re  = hi_re ? VMAX[W-1:0] : (lo_re ? VMIN[W-1:0] : v_re[W-1:0]);
    s_im  = hi_im ? VMAX[W-1:0] : (lo_im ? VMIN[W-1:0] : v_im[W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (in_op == OP_DIV && in_dz) begin
        out_res_re_r <= '0;
        out_res_im_r <= '0;
        out_status_r <= ST_DIV_ZERO;
      end else begin
        out_res_re_r <= s_re;
        out_res_im_r <= s_im;
        out_status_r <= (hi_re || lo_re || hi_im || lo_im) ? ST_SAT : ST_OK;
      end
    end
  end

endmodule

[sv/complex_arithmetic_unit.sv]
`timescale 1ns / 1ps
// Complex arithmetic unit: add, subtract, multiply and divide on signed
// fixed-point complex operands (Q16.16 by default), one transfer in and one
// result out per cycle at full rate. Most of the pipeline is the restoring
// divider, which produces one quotient bit per stage; every operation runs
// through the same pipeline so results leave in order. The whole pipeline
// advances together, so while a result waits at the output the input
// channel is held off. Overflowing parts saturate with status 1; divide by
// zero returns zero with status 2.
module complex_arithmetic_unit import cau_pkg::*; #(
  parameter int WORD_W = WORD_BITS,
  parameter int FRAC_W = FRAC_BITS
) (
  input logic     clk,
  input logic     rst_n,
  cau_in_if.sink  in_ch,
  cau_out_if.source out_ch
);

  localparam int SW  = 2*WORD_W + 1;
  localparam int NW  = SW + FRAC_W;
  localparam int DW  = 2*WORD_W;
  localparam int SBW = 5 + 2*SW;

  logic en;

  logic                 f_valid, f_dz, f_neg_re, f_neg_im;
  op_t                  f_op;
  logic signed [SW-1:0] f_alt_re, f_alt_im;
  logic [NW-1:0]        f_num_re, f_num_im;
  logic [DW-1:0]        f_den;

  logic          d_valid [NW+1];
  logic [DW-1:0] d_rem_re [NW+1];
  logic [DW-1:0] d_rem_im [NW+1];
  logic [NW-1:0] d_num_re [NW+1];
  logic [NW-1:0] d_num_im [NW+1];
  logic [NW-1:0] d_quo_re [NW+1];
  logic [NW-1:0] d_quo_im [NW+1];
  logic [DW-1:0] d_den [NW+1];
  logic [SBW-1:0] d_side [NW+1];

  logic                 s_dz, s_neg_re, s_neg_im;
  logic [1:0]           s_op;
  logic signed [SW-1:0] s_alt_re, s_alt_im;

  // global advance: move whenever the output register is free or drained
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  cau_front #(.W(WORD_W), .F(FRAC_W)) u_front (
    .clk, .rst_n, .en,
    .in_valid   (in_ch.valid),
    .in_op      (in_ch.req_type),
    .in_a_re    (in_ch.a_re),
    .in_a_im    (in_ch.a_im),
    .in_b_re    (in_ch.b_re),
    .in_b_im    (in_ch.b_im),
    .out_valid  (f_valid),
    .out_op     (f_op),
    .out_dz     (f_dz),
    .out_neg_re (f_neg_re),
    .out_neg_im (f_neg_im),
    .out_alt_re (f_alt_re),
    .out_alt_im (f_alt_im),
    .out_num_re (f_num_re),
    .out_num_im (f_num_im),
    .out_den    (f_den)
  );

  // divider entry
  assign d_valid[0]  = f_valid;
  assign d_rem_re[0] = '0;
  assign d_rem_im[0] = '0;
  assign d_num_re[0] = f_num_re;
  assign d_num_im[0] = f_num_im;
  assign d_quo_re[0] = '0;
  assign d_quo_im[0] = '0;
  assign d_den[0]    = f_den;
  assign d_side[0]   = {f_op, f_dz, f_neg_re, f_neg_im, f_alt_re, f_alt_im};

  for (genvar i = 0; i < NW; i++) begin : g_div
    cau_div_step #(.W(WORD_W), .F(FRAC_W), .SBW(SBW)) u_step (
      .clk, .rst_n, .en,
      .in_valid   (d_valid[i]),
      .in_rem_re  (d_rem_re[i]),
      .in_rem_im  (d_rem_im[i]),
      .in_num_re  (d_num_re[i]),
      .in_num_im  (d_num_im[i]),
      .in_quo_re  (d_quo_re[i]),
      .in_quo_im  (d_quo_im[i]),
      .in_den     (d_den[i]),
      .in_side    (d_side[i]),
      .out_valid  (d_valid[i+1]),
      .out_rem_re (d_rem_re[i+1]),
      .out_rem_im (d_rem_im[i+1]),
      .out_num_re (d_num_re[i+1]),
      .out_num_im (d_num_im[i+1]),
      .out_quo_re (d_quo_re[i+1]),
      .out_quo_im (d_quo_im[i+1]),
      .out_den    (d_den[i+1]),
      .out_side   (d_side[i+1])
    );
  end

  assign {s_op, s_dz, s_neg_re, s_neg_im, s_alt_re, s_alt_im} = d_side[NW];

  cau_sat #(.W(WORD_W), .F(FRAC_W)) u_sat (
    .clk, .rst_n, .en,
    .in_valid     (d_valid[NW]),
    .in_op        (op_t'(s_op)),
    .in_dz        (s_dz),
    .in_neg_re    (s_neg_re),
    .in_neg_im    (s_neg_im),
    .in_alt_re    (s_alt_re),
    .in_alt_im    (s_alt_im),
    .in_quo_re    (d_quo_re[NW]),
    .in_quo_im    (d_quo_im[NW]),
    .out_valid_r  (out_ch.valid),
    .out_res_re_r (out_ch.res_re),
    .out_res_im_r (out_ch.res_im),
    .out_status_r (out_ch.status)
  );

endmodule

[sv/cau_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the complex arithmetic unit, bound to the top level.
module cau_checker import cau_pkg::*; #(
  parameter int W = WORD_BITS
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic signed [W-1:0] res_re,
  input logic signed [W-1:0] res_im,
  input status_t             status
);

  localparam logic signed [W-1:0] RMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] RMIN = {1'b1, {(W-1){1'b0}}};

  // only the defined status codes are produced
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> status == ST_OK || status == ST_SAT || status == ST_DIV_ZERO)
    else $error("reserved status code on output");

  // divide by zero carries a zero result
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_DIV_ZERO |-> res_re == '0 && res_im == '0)
    else $error("divide by zero result not zero");

  // saturation flag means at least one part sits at a rail
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_SAT |->
      res_re == RMAX || res_re == RMIN || res_im == RMAX || res_im == RMIN)
    else $error("saturation status without a saturated part");

  // input is taken whenever the output register is empty
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(res_re) && $stable(res_im)
      && $stable(status))
    else $error("stalled result changed");

endmodule

bind complex_arithmetic_unit cau_checker #(.W(WORD_W)) u_cau_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .res_re    (out_ch.res_re),
  .res_im    (out_ch.res_im),
  .status    (out_ch.status)
);
